[sv/pfde_pkg.sv]
`default_nettype none

package pfde_pkg;

  // Signed width of the clipping arithmetic: covers pos + size and the panel edge.
  localparam int unsigned GEOM_W = 11;

  localparam logic [2:0] ACT_PIXEL = 3'd0;
  localparam logic [2:0] ACT_SPAN  = 3'd1;
  localparam logic [2:0] ACT_RECT  = 3'd2;
  localparam logic [2:0] ACT_CLEAR = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  localparam logic [1:0] PAINT_BLACK  = 2'd0;
  localparam logic [1:0] PAINT_WHITE  = 2'd1;
  localparam logic [1:0] PAINT_INVERT = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_READ_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_read;
    logic draw_rd;
    logic draw_wr;
    logic clr_start;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic draw_go;
    logic last_byte;
    logic clr_done;
  } status_t;

endpackage

`default_nettype wire

[sv/pfde_ram.sv]
`default_nettype none

module pfde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/pfde_datapath.sv]
`default_nettype none

module pfde_datapath
  import pfde_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH = 128,
  parameter int unsigned PANEL_PAGES = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  input  wire logic        [2:0] action_i,
  input  wire logic signed [8:0] pos_x_i,
  input  wire logic signed [8:0] pos_y_i,
  input  wire logic        [7:0] span_width_i,
  input  wire logic        [7:0] span_height_i,
  input  wire logic        [1:0] paint_i,
  input  wire logic        [8:0] read_address_i,
  output logic             [7:0] read_data_o
);

  localparam int unsigned DEPTH = PANEL_WIDTH * PANEL_PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(PANEL_WIDTH);
  localparam int unsigned PGW   = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
  localparam logic signed [GEOM_W-1:0] PW_S   = GEOM_W'(PANEL_WIDTH);
  localparam logic signed [GEOM_W-1:0] ROWS_S = GEOM_W'(PANEL_PAGES * 8);
  localparam logic signed [GEOM_W-1:0] ONE_S  = GEOM_W'(1);
  localparam logic [AW-1:0] PW_A       = AW'(PANEL_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

  // Clipping of the request to the panel
  logic signed [GEOM_W-1:0] px_s, py_s, wx_s, hy_s;
  logic signed [GEOM_W-1:0] c_end, r_end, c_lo, c_hi, r_lo, r_hi, c_last, r_last;
  logic                     col_ok, row_ok, paint_ok;
  logic [PGW-1:0]           first_pg_d, last_pg_d;
  logic [7:0]               fmask_d, lmask_d;
  logic [AW-1:0]            base_d;

  always_comb begin
    px_s   = GEOM_W'(pos_x_i);
    py_s   = GEOM_W'(pos_y_i);
    wx_s   = (action_i == ACT_RECT) ? GEOM_W'(span_width_i) : ONE_S;
    hy_s   = (action_i == ACT_PIXEL) ? ONE_S : GEOM_W'(span_height_i);
    c_end  = px_s + wx_s;
    r_end  = py_s + hy_s;
    c_lo   = px_s[GEOM_W-1] ? '0 : px_s;
    r_lo   = py_s[GEOM_W-1] ? '0 : py_s;
    c_hi   = (c_end > PW_S) ? PW_S : c_end;
    r_hi   = (r_end > ROWS_S) ? ROWS_S : r_end;
    c_last = c_hi - ONE_S;
    r_last = r_hi - ONE_S;
    col_ok = c_lo < c_hi;
    row_ok = r_lo < r_hi;
    paint_ok = (paint_i == PAINT_BLACK) || (paint_i == PAINT_WHITE) ||
               (paint_i == PAINT_INVERT);
    first_pg_d = PGW'(r_lo[GEOM_W-1:3]);
    last_pg_d  = PGW'(r_last[GEOM_W-1:3]);
    fmask_d    = 8'hFF << r_lo[2:0];
    lmask_d    = 8'hFF >> (3'd7 - r_last[2:0]);
    base_d     = AW'(first_pg_d) * PW_A + AW'(c_lo[CW-1:0]);
  end

  // Walk state: pages inside a column, then the next column
  logic [1:0]     paint_q;
  logic [CW-1:0]  col_q, col_last_q;
  logic [PGW-1:0] page_q, first_pg_q, last_pg_q;
  logic [7:0]     fmask_q, lmask_q;
  logic [AW-1:0]  base_q, addr_q, clr_q;
  logic           in_range_q;
  logic           page_last, col_last;

  assign page_last = page_q == last_pg_q;
  assign col_last  = col_q == col_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      paint_q    <= paint_i;
      col_q      <= c_lo[CW-1:0];
      col_last_q <= c_last[CW-1:0];
      page_q     <= first_pg_d;
      first_pg_q <= first_pg_d;
      last_pg_q  <= last_pg_d;
      fmask_q    <= fmask_d;
      lmask_q    <= lmask_d;
      base_q     <= base_d;
      addr_q     <= base_d;
      in_range_q <= 32'(read_address_i) < 32'(DEPTH);
    end else if (cmd_i.draw_wr) begin
      if (page_last) begin
        col_q  <= col_q + CW'(1);
        base_q <= base_q + AW'(1);
        addr_q <= base_q + AW'(1);
        page_q <= first_pg_q;
      end else begin
        page_q <= page_q + PGW'(1);
        addr_q <= addr_q + PW_A;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Read-modify-write of one byte
  logic [7:0] ram_rdata, mask, new_byte;

  always_comb begin
    mask = (page_q == first_pg_q ? fmask_q : 8'hFF) & (page_last ? lmask_q : 8'hFF);
    case (paint_q)
      PAINT_BLACK:  new_byte = ram_rdata & ~mask;
      PAINT_WHITE:  new_byte = ram_rdata | mask;
      PAINT_INVERT: new_byte = ram_rdata ^ mask;
      default:      new_byte = ram_rdata;
    endcase
  end

  pfde_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_wr | cmd_i.draw_wr),
    .waddr_i (cmd_i.clr_wr ? clr_q : addr_q),
    .wdata_i (cmd_i.clr_wr ? 8'h00 : new_byte),
    .re_i    (cmd_i.rd_read | cmd_i.draw_rd),
    .raddr_i (cmd_i.rd_read ? AW'(read_address_i) : addr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      read_data_o <= in_range_q ? ram_rdata : 8'h00;
    end
  end

  assign status_o.draw_go   = col_ok && row_ok && paint_ok;
  assign status_o.last_byte = page_last && col_last;
  assign status_o.clr_done  = clr_q == LAST_ADDR;

`ifndef SYNTHESIS
  a_draw_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.draw_wr |-> (32'(addr_q) < 32'(DEPTH)))
    else $error("draw write outside the store");

  a_clear_no_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_wr |-> !cmd_i.draw_wr && !cmd_i.draw_rd && !cmd_i.rd_read)
    else $error("store access during clearing pass");
`endif

endmodule

`default_nettype wire

[sv/pfde_ctrl.sv]
`default_nettype none

module pfde_ctrl
  import pfde_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] action_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire status_t    status_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, out_free;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            ACT_PIXEL, ACT_SPAN, ACT_RECT: begin
              if (status_i.draw_go) state_d = ST_DRAW_RD;
            end
            ACT_CLEAR: state_d = ST_CLEAR;
            ACT_READ:  state_d = ST_READ_OUT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_DRAW_RD: state_d = ST_DRAW_WR;
      ST_DRAW_WR: begin
        if (status_i.last_byte) state_d = ST_IDLE;
        else                    state_d = ST_DRAW_RD;
      end
      ST_READ_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = accept;
    cmd_o.rd_read   = accept && (action_i == ACT_READ);
    cmd_o.clr_start = accept && (action_i == ACT_CLEAR);
    case (state_q)
      ST_CLEAR:    cmd_o.clr_wr   = 1'b1;
      ST_DRAW_RD:  cmd_o.draw_rd  = 1'b1;
      ST_DRAW_WR:  cmd_o.draw_wr  = 1'b1;
      ST_READ_OUT: cmd_o.out_load = out_free;
      default:     cmd_o.clr_wr   = 1'b0;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_READ_OUT))
    else $error("result without a read request");

  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ACT_CLEAR) |=> state_q == ST_CLEAR)
    else $error("clear request did not start the sweep");

  a_rmw_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAW_RD |=> state_q == ST_DRAW_WR)
    else $error("byte read not followed by its write");
`endif

endmodule

`default_nettype wire

[sv/page_framebuffer_draw_engine_top.sv]
`default_nettype none

// Monochrome page-mode framebuffer, PANEL_WIDTH columns by PANEL_PAGES*8 rows.
// Input channel (in_valid_i / in_stall_o) carries one drawing request: pixel,
// vertical span, rectangle fill, clear all, or read one byte. Only the read
// request produces a result on the output channel (out_valid_o / out_stall_i),
// read_data_o being zero for an address past the end of the store.
// Requests are taken one at a time. Each touched byte is read from the store
// in ST_DRAW_RD and written back in ST_DRAW_WR; the store has separate read
// and write ports. Clear all walks the store one byte a cycle. A read request
// passes through the store's read register and then the output register,
// and the block is ready again once the result is loaded there. After reset
// the same clearing pass runs with in_stall_o high. A stalled result is held
// in the output register; drawing requests keep being taken meanwhile, a
// further read waits for the slot.

module page_framebuffer_draw_engine_top
  import pfde_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH = 128,
  parameter int unsigned PANEL_PAGES = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic        [2:0] action_i,
  input  wire logic signed [8:0] pos_x_i,
  input  wire logic signed [8:0] pos_y_i,
  input  wire logic        [7:0] span_width_i,
  input  wire logic        [7:0] span_height_i,
  input  wire logic        [1:0] paint_i,
  input  wire logic        [8:0] read_address_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic             [7:0] read_data_o
);

  cmd_t    cmd;
  status_t status;

  pfde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pfde_datapath #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_PAGES (PANEL_PAGES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (action_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .span_width_i   (span_width_i),
    .span_height_i  (span_height_i),
    .paint_i        (paint_i),
    .read_address_i (read_address_i),
    .read_data_o    (read_data_o)
  );

endmodule

`default_nettype wire
